FILE: rtl/midpoint_circle_rasterizer_unit_defines.svh
// Assertion macros used by the circle rasterizer RTL.
`ifndef MIDPOINT_CIRCLE_RASTERIZER_UNIT_DEFINES_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_UNIT_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define MCR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define MCR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/mcr_pkg.sv
// Shared types and constants of the circle rasterizer.
package mcr_pkg;

   localparam int RAD_BITS      = 7;
   localparam int WIDTH_BITS    = 13;
   localparam int COLOR_BITS    = 8;

   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 13;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PLANE_WIDTH = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PIXEL_COLOR = 1'd1;

   localparam logic [WIDTH_BITS-1:0] PLANE_WIDTH_RESET = 13'd1024;
   localparam logic [COLOR_BITS-1:0] PIXEL_COLOR_RESET = 8'd1;

   // step offsets: dy runs from radius down to -1
   localparam int OFS_BITS = 8;
   // decision value stays within about -330 .. 254
   localparam int DEC_BITS = 11;
   localparam logic signed [DEC_BITS-1:0] DEC_INIT    = 11'sd3;
   localparam logic signed [DEC_BITS-1:0] DEC_STEP_X  = 11'sd6;
   localparam logic signed [DEC_BITS-1:0] DEC_STEP_XY = 11'sd10;

   localparam int GROUP_LIMIT = 64;
   localparam int GRP_BITS    = 6;
   localparam int NUM_PIX     = 8;

   localparam int Q_DEPTH     = 2;
   localparam int Q_PTR_BITS  = 1;
   localparam int Q_CNT_BITS  = 2;

   typedef struct packed {
      logic full;
      logic empty;
   } mcr_qstat_type;

endpackage

FILE: rtl/mcr_front.sv
// Front end: takes a circle, clamps the radius and forms the row products.
module mcr_front #(
   parameter int MAX_RADIUS = 85,
   parameter int COORD_BITS = 12,
   parameter int ADDR_BITS  = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [COORD_BITS-1:0]               req_center_x,
   input  logic [COORD_BITS-1:0]               req_center_y,
   input  logic [mcr_pkg::RAD_BITS-1:0]        req_radius,
   input  logic [mcr_pkg::WIDTH_BITS-1:0]      plane_width_i,
   input  mcr_pkg::mcr_qstat_type              qstat_i,
   output logic                                push_o,
   output logic [COORD_BITS+2*ADDR_BITS+mcr_pkg::RAD_BITS-1:0] job_o
);

   localparam int PROD_W = COORD_BITS + mcr_pkg::WIDTH_BITS;
   localparam int RW_W   = mcr_pkg::RAD_BITS + mcr_pkg::WIDTH_BITS;

   logic                           f_vld_ff, f_vld_in;
   logic [COORD_BITS-1:0]          cx_ff, cx_in;
   logic [COORD_BITS-1:0]          cy_ff, cy_in;
   logic [mcr_pkg::RAD_BITS-1:0]   r_ff, r_in;
   logic                           accept;
   logic [PROD_W-1:0]              base_prod;
   logic [RW_W-1:0]                rw_prod;

   assign busy   = f_vld_ff & qstat_i.full;
   assign accept = start & ~busy;
   assign push_o = f_vld_ff & ~qstat_i.full;

   always_comb begin
      f_vld_in = accept | (f_vld_ff & ~push_o);
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      r_in     = r_ff;
      if (accept) begin
         cx_in = req_center_x;
         cy_in = req_center_y;
         // radius saturates at the configured maximum
         if (req_radius > mcr_pkg::RAD_BITS'(MAX_RADIUS)) begin
            r_in = mcr_pkg::RAD_BITS'(MAX_RADIUS);
         end else begin
            r_in = req_radius;
         end
      end
   end

   // row base cy*W and initial dy*W, both mod 2^ADDR_BITS
   assign base_prod = PROD_W'(cy_ff) * PROD_W'(plane_width_i);
   assign rw_prod   = RW_W'(r_ff) * RW_W'(plane_width_i);
   assign job_o     = {cx_ff, ADDR_BITS'(base_prod), r_ff, ADDR_BITS'(rw_prod)};

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else begin
         f_vld_ff <= f_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      r_ff  <= r_in;
   end

endmodule

FILE: rtl/mcr_queue.sv
// Two-entry job queue between front end and stepping engine.
module mcr_queue #(
   parameter int JOB_W = 67
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_i,
   input  logic [JOB_W-1:0]       job_i,
   input  logic                   pop_i,
   output logic [JOB_W-1:0]       job_o,
   output mcr_pkg::mcr_qstat_type qstat_o
);

   logic [JOB_W-1:0]                   mem_ff [mcr_pkg::Q_DEPTH];
   logic [mcr_pkg::Q_PTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [mcr_pkg::Q_PTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [mcr_pkg::Q_CNT_BITS-1:0]     cnt_ff, cnt_in;

   assign qstat_o.full  = (cnt_ff == mcr_pkg::Q_CNT_BITS'(mcr_pkg::Q_DEPTH));
   assign qstat_o.empty = (cnt_ff == '0);
   assign job_o         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_i) begin
         wr_ptr_in = wr_ptr_ff + mcr_pkg::Q_PTR_BITS'(1);
      end
      if (pop_i) begin
         rd_ptr_in = rd_ptr_ff + mcr_pkg::Q_PTR_BITS'(1);
      end
      unique case ({push_i, pop_i})
         2'b10:   cnt_in = cnt_ff + mcr_pkg::Q_CNT_BITS'(1);
         2'b01:   cnt_in = cnt_ff - mcr_pkg::Q_CNT_BITS'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         mem_ff[wr_ptr_ff] <= job_i;
      end
   end

endmodule

FILE: rtl/mcr_back.sv
// Stepping engine: walks one octant and emits eight addresses per step.
`include "midpoint_circle_rasterizer_unit_defines.svh"

module mcr_back #(
   parameter int COORD_BITS = 12,
   parameter int ADDR_BITS  = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [COORD_BITS+2*ADDR_BITS+mcr_pkg::RAD_BITS-1:0] job_i,
   input  logic                                job_avail_i,
   output logic                                pop_o,
   input  logic [mcr_pkg::WIDTH_BITS-1:0]      plane_width_i,
   input  logic [mcr_pkg::COLOR_BITS-1:0]      pixel_color_i,
   output logic                                rsp_valid,
   output logic [ADDR_BITS-1:0]                rsp_addr_0,
   output logic [ADDR_BITS-1:0]                rsp_addr_1,
   output logic [ADDR_BITS-1:0]                rsp_addr_2,
   output logic [ADDR_BITS-1:0]                rsp_addr_3,
   output logic [ADDR_BITS-1:0]                rsp_addr_4,
   output logic [ADDR_BITS-1:0]                rsp_addr_5,
   output logic [ADDR_BITS-1:0]                rsp_addr_6,
   output logic [ADDR_BITS-1:0]                rsp_addr_7,
   output logic [mcr_pkg::COLOR_BITS-1:0]      rsp_color,
   output logic                                rsp_last_group
);

   localparam int JOB_W = COORD_BITS + 2*ADDR_BITS + mcr_pkg::RAD_BITS;
   localparam int RB    = mcr_pkg::RAD_BITS;

   logic [COORD_BITS-1:0]   j_cx;
   logic [ADDR_BITS-1:0]    j_base, j_rw;
   logic [RB-1:0]           j_r;

   logic                                  act_ff, act_in;
   logic signed [mcr_pkg::OFS_BITS-1:0]   dx_ff, dx_in;
   logic signed [mcr_pkg::OFS_BITS-1:0]   dy_ff, dy_in;
   logic signed [mcr_pkg::DEC_BITS-1:0]   d_ff, d_in;
   logic [ADDR_BITS-1:0]                  dxw_ff, dxw_in;
   logic [ADDR_BITS-1:0]                  dyw_ff, dyw_in;
   logic [ADDR_BITS-1:0]                  base_ff, base_in;
   logic [COORD_BITS-1:0]                 cx_ff, cx_in;
   logic [mcr_pkg::GRP_BITS-1:0]          cnt_ff, cnt_in;

   logic                                  last_now, load;
   logic signed [mcr_pkg::DEC_BITS-1:0]   dx_d, dy_d;
   logic [ADDR_BITS-1:0]                  w_a, cx_a, dx_a, dy_a;
   logic [ADDR_BITS-1:0]                  x_pdx, x_mdx, x_pdy, x_mdy;
   logic [ADDR_BITS-1:0]                  r_pdy, r_mdy, r_pdx, r_mdx;

   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [ADDR_BITS-1:0]                  addr_ff [mcr_pkg::NUM_PIX];
   logic [ADDR_BITS-1:0]                  addr_in [mcr_pkg::NUM_PIX];
   logic [mcr_pkg::COLOR_BITS-1:0]        color_ff, color_in;
   logic                                  last_ff, last_in;

   assign j_cx   = job_i[JOB_W-1 -: COORD_BITS];
   assign j_base = job_i[2*ADDR_BITS+RB-1 -: ADDR_BITS];
   assign j_r    = job_i[ADDR_BITS+RB-1 -: RB];
   assign j_rw   = job_i[ADDR_BITS-1:0];

   // the group on hand is the last one once dx passes dy or the cap is hit
   assign last_now = (dx_ff > dy_ff) ||
                     (cnt_ff == mcr_pkg::GRP_BITS'(mcr_pkg::GROUP_LIMIT - 1));
   assign load     = job_avail_i & (~act_ff | last_now);
   assign pop_o    = load;

   assign dx_d = mcr_pkg::DEC_BITS'(dx_ff);
   assign dy_d = mcr_pkg::DEC_BITS'(dy_ff);
   assign w_a  = ADDR_BITS'(plane_width_i);

   always_comb begin
      act_in  = act_ff & ~last_now;
      dx_in   = dx_ff;
      dy_in   = dy_ff;
      d_in    = d_ff;
      dxw_in  = dxw_ff;
      dyw_in  = dyw_ff;
      base_in = base_ff;
      cx_in   = cx_ff;
      cnt_in  = cnt_ff + mcr_pkg::GRP_BITS'(1);
      if (load) begin
         act_in  = 1'b1;
         dx_in   = '0;
         dy_in   = mcr_pkg::OFS_BITS'(j_r);
         d_in    = mcr_pkg::DEC_INIT - (mcr_pkg::DEC_BITS'(j_r) << 1);
         dxw_in  = '0;
         dyw_in  = j_rw;
         base_in = j_base;
         cx_in   = j_cx;
         cnt_in  = '0;
      end else if (act_ff && !last_now) begin
         dx_in  = dx_ff + mcr_pkg::OFS_BITS'(1);
         dxw_in = dxw_ff + w_a;
         if (d_ff[mcr_pkg::DEC_BITS-1]) begin
            d_in = d_ff + (dx_d <<< 2) + mcr_pkg::DEC_STEP_X;
         end else begin
            d_in   = d_ff + ((dx_d - dy_d) <<< 2) + mcr_pkg::DEC_STEP_XY;
            dy_in  = dy_ff - mcr_pkg::OFS_BITS'(1);
            dyw_in = dyw_ff - w_a;
         end
      end
   end

   // columns and rows of the eight mirrored pixels, all mod 2^ADDR_BITS
   assign cx_a  = ADDR_BITS'(cx_ff);
   assign dx_a  = ADDR_BITS'(dx_ff);
   assign dy_a  = ADDR_BITS'(dy_ff);
   assign x_pdx = cx_a + dx_a;
   assign x_mdx = cx_a - dx_a;
   assign x_pdy = cx_a + dy_a;
   assign x_mdy = cx_a - dy_a;
   assign r_pdy = base_ff + dyw_ff;
   assign r_mdy = base_ff - dyw_ff;
   assign r_pdx = base_ff + dxw_ff;
   assign r_mdx = base_ff - dxw_ff;

   always_comb begin
      rsp_valid_in = act_ff;
      addr_in[0]   = x_pdx + r_pdy;
      addr_in[1]   = x_pdx + r_mdy;
      addr_in[2]   = x_mdx + r_pdy;
      addr_in[3]   = x_mdx + r_mdy;
      addr_in[4]   = x_pdy + r_pdx;
      addr_in[5]   = x_pdy + r_mdx;
      addr_in[6]   = x_mdy + r_pdx;
      addr_in[7]   = x_mdy + r_mdx;
      color_in     = pixel_color_i;
      last_in      = last_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         act_ff       <= act_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      d_ff     <= d_in;
      dxw_ff   <= dxw_in;
      dyw_ff   <= dyw_in;
      base_ff  <= base_in;
      cx_ff    <= cx_in;
      cnt_ff   <= cnt_in;
      addr_ff  <= addr_in;
      color_ff <= color_in;
      last_ff  <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_addr_0     = addr_ff[0];
   assign rsp_addr_1     = addr_ff[1];
   assign rsp_addr_2     = addr_ff[2];
   assign rsp_addr_3     = addr_ff[3];
   assign rsp_addr_4     = addr_ff[4];
   assign rsp_addr_5     = addr_ff[5];
   assign rsp_addr_6     = addr_ff[6];
   assign rsp_addr_7     = addr_ff[7];
   assign rsp_color      = color_ff;
   assign rsp_last_group = last_ff;

   `MCR_ASSERT_NEXT(a_step_emits, act_ff, rsp_valid_ff, "active step produced no group")
   `MCR_ASSERT_NEXT(a_no_stray_beat, !act_ff, !rsp_valid_ff, "group strobe with no work")
   `MCR_ASSERT_NOW(a_dy_floor, act_ff, dy_ff >= -8'sd1, "dy dropped below -1")
   `MCR_ASSERT_NEXT(a_drain_idle, act_ff && last_now && !job_avail_i, !act_ff, "engine ran past last group")

endmodule

FILE: rtl/midpoint_circle_rasterizer_unit.sv
// Top level of the midpoint circle rasterizer.
//
// One circle (center, radius) enters on a start beat while busy is low and
// comes out as a run of groups, one group per clock: each group carries the
// eight mirrored pixel addresses x + y*plane_width (mod 2^ADDR_BITS), the
// pixel color, and last_group on the final one. A run has about
// radius/sqrt(2) + 2 groups (two for radius zero, 62 at radius 85, never
// more than 64); the stepping engine produces one group per cycle, and
// circles queued behind it follow with no gap. Radius above MAX_RADIUS is
// clamped. When the engine is free and the queue is empty, a circle passes
// the front stage, the queue entry, the engine load and the output
// register before its first group shows.
// Results cannot be stalled: rsp_valid marks each group for exactly one
// cycle and the receiver must take it. Up to three circles may be held in
// flight ahead of the engine (front stage plus a two-entry queue); busy
// rises only when all are taken. The CSR port writes plane_width (index 0)
// and pixel_color (index 1); write them only while no circle is pending.
module midpoint_circle_rasterizer_unit #(
   parameter int MAX_RADIUS = 85,
   parameter int COORD_BITS = 12,
   parameter int ADDR_BITS  = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // circle input
   input  logic                                 start,
   output logic                                 busy,
   input  logic [COORD_BITS-1:0]                req_center_x,
   input  logic [COORD_BITS-1:0]                req_center_y,
   input  logic [mcr_pkg::RAD_BITS-1:0]         req_radius,
   // group output
   output logic                                 rsp_valid,
   output logic [ADDR_BITS-1:0]                 rsp_addr_0,
   output logic [ADDR_BITS-1:0]                 rsp_addr_1,
   output logic [ADDR_BITS-1:0]                 rsp_addr_2,
   output logic [ADDR_BITS-1:0]                 rsp_addr_3,
   output logic [ADDR_BITS-1:0]                 rsp_addr_4,
   output logic [ADDR_BITS-1:0]                 rsp_addr_5,
   output logic [ADDR_BITS-1:0]                 rsp_addr_6,
   output logic [ADDR_BITS-1:0]                 rsp_addr_7,
   output logic [mcr_pkg::COLOR_BITS-1:0]       rsp_color,
   output logic                                 rsp_last_group,
   // register writes
   input  logic                                 csr_write_en,
   input  logic [mcr_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [mcr_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int JOB_W = COORD_BITS + 2*ADDR_BITS + mcr_pkg::RAD_BITS;

   logic [mcr_pkg::WIDTH_BITS-1:0]  plane_width_ff, plane_width_in;
   logic [mcr_pkg::COLOR_BITS-1:0]  pixel_color_ff, pixel_color_in;

   logic                            push, pop;
   logic [JOB_W-1:0]                job_wr, job_rd;
   mcr_pkg::mcr_qstat_type          qstat;

   // CSR file: plain writes, no read-back
   always_comb begin
      plane_width_in = plane_width_ff;
      pixel_color_in = pixel_color_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            mcr_pkg::CSR_PLANE_WIDTH: plane_width_in = csr_wdata;
            mcr_pkg::CSR_PIXEL_COLOR: pixel_color_in = csr_wdata[mcr_pkg::COLOR_BITS-1:0];
            default:                  plane_width_in = plane_width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_width_ff <= mcr_pkg::PLANE_WIDTH_RESET;
         pixel_color_ff <= mcr_pkg::PIXEL_COLOR_RESET;
      end else begin
         plane_width_ff <= plane_width_in;
         pixel_color_ff <= pixel_color_in;
      end
   end

   // front: accept, clamp, row products
   mcr_front #(
      .MAX_RADIUS (MAX_RADIUS),
      .COORD_BITS (COORD_BITS),
      .ADDR_BITS  (ADDR_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_center_x  (req_center_x),
      .req_center_y  (req_center_y),
      .req_radius    (req_radius),
      .plane_width_i (plane_width_ff),
      .qstat_i       (qstat),
      .push_o        (push),
      .job_o         (job_wr)
   );

   // decoupling queue
   mcr_queue #(
      .JOB_W (JOB_W)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_i  (push),
      .job_i   (job_wr),
      .pop_i   (pop),
      .job_o   (job_rd),
      .qstat_o (qstat)
   );

   // back: octant walk, one group per cycle
   mcr_back #(
      .COORD_BITS (COORD_BITS),
      .ADDR_BITS  (ADDR_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .job_i          (job_rd),
      .job_avail_i    (~qstat.empty),
      .pop_o          (pop),
      .plane_width_i  (plane_width_ff),
      .pixel_color_i  (pixel_color_ff),
      .rsp_valid      (rsp_valid),
      .rsp_addr_0     (rsp_addr_0),
      .rsp_addr_1     (rsp_addr_1),
      .rsp_addr_2     (rsp_addr_2),
      .rsp_addr_3     (rsp_addr_3),
      .rsp_addr_4     (rsp_addr_4),
      .rsp_addr_5     (rsp_addr_5),
      .rsp_addr_6     (rsp_addr_6),
      .rsp_addr_7     (rsp_addr_7),
      .rsp_color      (rsp_color),
      .rsp_last_group (rsp_last_group)
   );

endmodule
